// File: rtl/slcd_pkg.sv
// Shared types, constants and segment table for the segment LCD number formatter.
package slcd_pkg;

	localparam int unsigned NUM_DIGITS  = 7;
	localparam int unsigned HEAD_BEATS  = 5;
	localparam int unsigned FRAME_BYTES = 16;
	localparam int unsigned TXN_BEATS   = HEAD_BEATS + FRAME_BYTES + 1;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] ADDR_RST   = 8'h70;
	localparam logic [7:0] MODE_RST   = 8'h48;
	localparam logic [7:0] SEL_RST    = 8'hE0;
	localparam logic [7:0] SIGN_MINUS = 8'h20;
	localparam logic [7:0] POINT_BIT  = 8'h08;
	localparam logic [7:0] ERROR_CODE = 8'h20;

	localparam logic [31:0] DIGIT_LIMIT = 32'd10000000;
	localparam logic [31:0] RECIP_10    = 32'hCCCCCCCD;

	typedef enum logic [1:0] {
		REG_ADDR = 2'd0,
		REG_MODE = 2'd1,
		REG_SEL  = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_CONV,
		FE_PUSH
	} fe_state_t;

	typedef enum logic {
		BE_IDLE,
		BE_SEND
	} be_state_t;

	typedef struct packed {
		logic        ovf;
		logic        neg;
		logic [2:0]  top;
		logic [NUM_DIGITS-1:0][3:0] digits;
	} item_t;

	typedef struct packed {
		logic [7:0] bus_address;
		logic [7:0] mode_word;
		logic [7:0] select_word;
	} cfg_t;

	function automatic logic [7:0] seg_code(input logic [3:0] digit);
		logic [7:0] code;
		case (digit)
			4'd0: code = 8'hD7;
			4'd1: code = 8'h03;
			4'd2: code = 8'hB6;
			4'd3: code = 8'hA7;
			4'd4: code = 8'h63;
			4'd5: code = 8'hE5;
			4'd6: code = 8'hF5;
			4'd7: code = 8'h07;
			4'd8: code = 8'hF7;
			4'd9: code = 8'hE7;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

endpackage

// File: rtl/slcd_queue.sv
// Small FIFO of converted items between the front and back parts.
module slcd_queue #(
	parameter int unsigned DEPTH = slcd_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  slcd_pkg::item_t push_data,
	output logic            full,
	input  logic            pop,
	output slcd_pkg::item_t pop_data,
	output logic            empty
);
	import slcd_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: rtl/slcd_front.sv
// Front part: takes a value, checks range and splits it into decimal digits.
module slcd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] value_centi,
	output logic               busy,
	input  logic               full,
	output logic               push,
	output slcd_pkg::item_t    push_data
);
	import slcd_pkg::*;

	fe_state_t   state_q;
	fe_state_t   state_d;
	logic [2:0]  cnt_q;
	logic        neg_q;
	logic        ovf_q;
	logic [23:0] t_q;
	logic [NUM_DIGITS-1:0][3:0] digits_q;

	logic        accept;
	logic [31:0] mag;
	logic [55:0] prod;
	logic [23:0] quot;
	logic [23:0] rem;
	logic [2:0]  top;

	assign busy   = (state_q != FE_IDLE);
	assign accept = start && !busy;
	assign mag    = value_centi[31] ? (~value_centi + 32'd1) : value_centi;

	// divide by ten through the reciprocal, exact for any 24-bit dividend
	assign prod = t_q * RECIP_10;
	assign quot = {3'b000, prod[55:35]};
	assign rem  = t_q - ((quot << 3) + (quot << 1));

	always_comb begin
		top = 3'd2;
		if (digits_q[6] != 4'd0) begin
			top = 3'd6;
		end else if (digits_q[5] != 4'd0) begin
			top = 3'd5;
		end else if (digits_q[4] != 4'd0) begin
			top = 3'd4;
		end else if (digits_q[3] != 4'd0) begin
			top = 3'd3;
		end
	end

	assign push_data.ovf    = ovf_q;
	assign push_data.neg    = neg_q;
	assign push_data.top    = top;
	assign push_data.digits = digits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		push    = 1'b0;
		case (state_q)
			FE_IDLE: begin
				if (accept) begin
					state_d = FE_CONV;
				end
			end
			FE_CONV: begin
				if (cnt_q == 3'(NUM_DIGITS - 1)) begin
					state_d = FE_PUSH;
				end
			end
			FE_PUSH: begin
				push = !full;
				if (!full) begin
					state_d = FE_IDLE;
				end
			end
			default: state_d = FE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= '0;
		end else if (state_q == FE_CONV) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= value_centi[31];
			ovf_q <= (mag >= DIGIT_LIMIT);
			t_q   <= mag[23:0];
		end else if (state_q == FE_CONV) begin
			t_q      <= quot;
			digits_q <= {rem[3:0], digits_q[NUM_DIGITS-1:1]};
		end
	end

endmodule

// File: rtl/slcd_back.sv
// Back part: sends the 22 bus bytes of one item, one beat per cycle.
module slcd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  slcd_pkg::cfg_t  cfg,
	input  logic            empty,
	input  slcd_pkg::item_t pop_data,
	output logic            pop,
	output logic            strobe,
	output logic [7:0]      bus_byte,
	output logic            start_before,
	output logic            stop_after,
	output logic            last_byte
);
	import slcd_pkg::*;

	localparam logic [4:0] BEAT_ADDR0 = 5'd0;
	localparam logic [4:0] BEAT_MODE  = 5'd1;
	localparam logic [4:0] BEAT_ADDR1 = 5'd2;
	localparam logic [4:0] BEAT_SEL   = 5'd3;
	localparam logic [4:0] BEAT_PTR   = 5'd4;
	localparam logic [4:0] BEAT_LAST  = 5'(TXN_BEATS - 1);
	localparam logic [4:0] FRAME_END  = 5'(HEAD_BEATS + FRAME_BYTES - 1);

	be_state_t  state_q;
	be_state_t  state_d;
	logic [4:0] cnt_q;
	item_t      item_q;

	logic       last;
	logic [4:0] idx;
	logic [4:0] sign_pos;
	logic [7:0] frame_byte;
	logic [7:0] byte_d;
	logic       st_d;
	logic       sp_d;
	logic       strobe_q;
	logic [7:0] byte_q;
	logic       st_q;
	logic       sp_q;
	logic       last_q;

	assign last = (cnt_q == BEAT_LAST);
	assign pop  = !empty && ((state_q == BE_IDLE) || last);

	// digit position counted from the units end of the frame
	assign idx      = FRAME_END - cnt_q;
	assign sign_pos = {2'b00, item_q.top} + 5'd1;

	always_comb begin
		if (item_q.ovf) begin
			frame_byte = ERROR_CODE;
		end else if (idx > sign_pos) begin
			frame_byte = 8'h00;
		end else if (idx == sign_pos) begin
			frame_byte = item_q.neg ? SIGN_MINUS : 8'h00;
		end else begin
			frame_byte = seg_code(item_q.digits[idx[2:0]]) |
				((idx == 5'd2) ? POINT_BIT : 8'h00);
		end
	end

	always_comb begin
		byte_d = frame_byte;
		st_d   = 1'b0;
		sp_d   = 1'b0;
		case (cnt_q)
			BEAT_ADDR0: begin
				byte_d = cfg.bus_address;
				st_d   = 1'b1;
			end
			BEAT_MODE: begin
				byte_d = cfg.mode_word;
				sp_d   = 1'b1;
			end
			BEAT_ADDR1: begin
				byte_d = cfg.bus_address;
				st_d   = 1'b1;
			end
			BEAT_SEL: byte_d = cfg.select_word;
			BEAT_PTR: byte_d = 8'h00;
			BEAT_LAST: begin
				byte_d = 8'h00;
				sp_d   = 1'b1;
			end
			default: byte_d = frame_byte;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BE_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BE_IDLE: begin
				if (pop) begin
					state_d = BE_SEND;
				end
			end
			BE_SEND: begin
				if (last && !pop) begin
					state_d = BE_IDLE;
				end
			end
			default: state_d = BE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == BE_SEND);
			if (pop) begin
				cnt_q <= '0;
			end else if (state_q == BE_SEND) begin
				cnt_q <= cnt_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= pop_data;
		end
		if (state_q == BE_SEND) begin
			byte_q <= byte_d;
			st_q   <= st_d;
			sp_q   <= sp_d;
			last_q <= last;
		end
	end

	assign strobe       = strobe_q;
	assign bus_byte     = byte_q;
	assign start_before = st_q;
	assign stop_after   = sp_q;
	assign last_byte    = last_q;

endmodule

// File: rtl/segment_lcd_number_formatter_unit.sv
// Top level of the segment LCD number formatter: config registers, front, queue, back.
//
//  channel   signals                                        direction
//  command   start, busy, value_centi                       in (busy out)
//  result    strobe, bus_byte, start_before, stop_after,    out
//            last_byte
//  config    wr_en, wr_index, wr_data                       in
//
// Each value gives 22 beats, one per cycle, so an item occupies the byte
// sender for all of its beats; that sender sets the sustained rate.
// The digit splitter runs ahead of the byte sender through the queue.
// With the queue empty, the first beat follows the split, the push and the pop.
// Reset returns the registers to 0x70, 0x48, 0xE0 and empties the queue.
// Results cannot be held off; busy stays high through splitting
// and push after a value is taken, and longer while the queue is full.
module segment_lcd_number_formatter_unit #(
	parameter int unsigned QUEUE_DEPTH = slcd_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] value_centi,
	output logic               strobe,
	output logic [7:0]         bus_byte,
	output logic               start_before,
	output logic               stop_after,
	output logic               last_byte,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [7:0]         wr_data
);
	import slcd_pkg::*;

	cfg_t  cfg_q;
	logic  push;
	logic  pop;
	logic  full;
	logic  empty;
	item_t push_data;
	item_t pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bus_address <= ADDR_RST;
			cfg_q.mode_word   <= MODE_RST;
			cfg_q.select_word <= SEL_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_ADDR: cfg_q.bus_address <= wr_data;
				REG_MODE: cfg_q.mode_word   <= wr_data;
				REG_SEL:  cfg_q.select_word <= wr_data;
				default: ;
			endcase
		end
	end

	slcd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.value_centi (value_centi),
		.busy        (busy),
		.full        (full),
		.push        (push),
		.push_data   (push_data)
	);

	slcd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	slcd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.empty        (empty),
		.pop_data     (pop_data),
		.pop          (pop),
		.strobe       (strobe),
		.bus_byte     (bus_byte),
		.start_before (start_before),
		.stop_after   (stop_after),
		.last_byte    (last_byte)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("front not busy after taking a value");

	a_last_stop: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_byte |-> stop_after)
		else $error("final beat without stop");

	a_next_txn_start: assert property (@(posedge clk) disable iff (!arst_n)
		$past(strobe) && $past(last_byte) && strobe |-> start_before)
		else $error("transaction does not open with start");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |-> !push)
		else $error("push into full queue");

endmodule
